// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, sampled on aclk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define TCLI_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("tcli: assertion failed");

// condition must never be seen at a clock edge out of reset
`define TCLI_NEVER(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("tcli: forbidden condition seen");

`endif

// ===== rtl/tcli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcli_pkg
// Shared types and constants of the transfer curve LUT interpolator.
// ----------------------------------------------------------------------------
package tcli_pkg;

    localparam int ENTRY_W  = 16;   // table entry / load index width
    localparam int SAMPLE_W = 18;   // signed Q2.16 sample
    localparam int RESULT_W = 19;   // signed Q3.16 result
    localparam int USED_W   = 17;   // used_entries register
    localparam int POS_W    = 35;   // signed table position sample * (n - 1)
    localparam int NUM_W    = 53;   // signed numerator before the divide
    localparam int PROD_W   = 35;   // each partial product of slope * frac

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QLVL_W   = 3;

    // input kinds (tuser)
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    // entry formats
    localparam logic FMT_BYTE = 1'b0;
    localparam logic FMT_WORD = 1'b1;

    // configuration register indexes
    localparam logic REG_USED_ENTRIES = 1'b0;
    localparam logic REG_ENTRY_FORMAT = 1'b1;

    localparam logic [USED_W-1:0] USED_ENTRIES_RST = 17'd256;
    localparam logic              ENTRY_FORMAT_RST = FMT_WORD;

    // 262144 * 65535: numerator bound where the result leaves Q3.16
    localparam logic signed [NUM_W-1:0] SAT_HI = 53'sd17179607040;
    localparam logic signed [NUM_W-1:0] SAT_LO = -53'sd17179607040;
    localparam logic [POS_W-1:0]        SAT_OFS = 35'd17179607040;
    localparam logic [NUM_W-1:0]        ROUND_HALF = 53'd32767;

    localparam logic signed [RESULT_W-1:0] RES_MAX = 19'sh3FFFF;
    localparam logic signed [RESULT_W-1:0] RES_MIN = 19'sh40000;

    typedef struct packed {
        logic [USED_W-1:0] used_entries;
        logic              entry_format;
    } cfg_t;

    // one queued operation: a table write or an evaluate with base and fraction
    typedef struct packed {
        logic                    is_load;
        logic [ENTRY_W-1:0]      addr;
        logic [ENTRY_W-1:0]      wval;
        logic signed [POS_W-1:0] frac;
    } qent_t;

    typedef struct packed {
        logic              not_empty;
        logic [QLVL_W-1:0] level;
    } qstat_t;

endpackage

// ===== rtl/tcli_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcli_front
// Accepts input transfers, formats loads, scales samples to a table
// position and splits it into segment base and fraction for the queue.
// ----------------------------------------------------------------------------
module tcli_front #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tcli_pkg::cfg_t       cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [55:0]          s_tdata,
    input  logic                 s_tuser,
    input  tcli_pkg::qstat_t     q_stat,
    output logic                 q_push,
    output tcli_pkg::qent_t      q_entry
);

    logic s_accept;

    logic                                   f0_valid_reg;
    logic                                   f0_mode_reg;
    logic [tcli_pkg::ENTRY_W-1:0]           f0_idx_reg;
    logic [tcli_pkg::ENTRY_W-1:0]           f0_val_reg;
    logic signed [tcli_pkg::SAMPLE_W-1:0]   f0_sample_reg;

    logic                                   f1_valid_reg;
    logic                                   f1_mode_reg;
    logic [tcli_pkg::ENTRY_W-1:0]           f1_idx_reg;
    logic [tcli_pkg::ENTRY_W-1:0]           f1_val_reg;
    logic signed [tcli_pkg::POS_W-1:0]      pos_reg;
    logic signed [tcli_pkg::POS_W-1:0]      pos_next;

    logic [tcli_pkg::USED_W-1:0]            n_clamp;
    logic [tcli_pkg::ENTRY_W-1:0]           seg_reg;       // n - 1
    logic [tcli_pkg::ENTRY_W-1:0]           seg_last_reg;  // n - 2, last base
    logic [tcli_pkg::ENTRY_W-1:0]           word_val;

    logic [18:0]                            base_raw;
    logic [tcli_pkg::ENTRY_W-1:0]           base;
    logic                                   load_in_range;
    logic [3:0]                             in_flight;

    // credit: everything in flight must still fit in the queue
    assign in_flight = {1'b0, q_stat.level} + 4'(f0_valid_reg) + 4'(f1_valid_reg);
    assign s_tready  = in_flight < 4'(tcli_pkg::QDEPTH);
    assign s_accept  = s_tvalid && s_tready;

    assign word_val = (cfg.entry_format == tcli_pkg::FMT_BYTE) ?
                      {s_tdata[23:16], s_tdata[23:16]} : s_tdata[31:16];

    always_comb begin
        if (cfg.used_entries < 17'd2) begin
            n_clamp = 17'd2;
        end else if (cfg.used_entries > 17'(TABLE_DEPTH)) begin
            n_clamp = 17'(TABLE_DEPTH);
        end else begin
            n_clamp = cfg.used_entries;
        end
    end

    always_ff @(posedge aclk) begin
        seg_reg      <= 16'(n_clamp - 17'd1);
        seg_last_reg <= 16'(n_clamp - 17'd2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
        end else begin
            f0_valid_reg <= s_accept;
            f1_valid_reg <= f0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            f0_mode_reg   <= s_tuser;
            f0_idx_reg    <= s_tdata[15:0];
            f0_val_reg    <= word_val;
            f0_sample_reg <= $signed(s_tdata[49:32]);
        end
    end

    assign pos_next = f0_sample_reg * $signed({1'b0, seg_reg});

    always_ff @(posedge aclk) begin
        f1_mode_reg <= f0_mode_reg;
        f1_idx_reg  <= f0_idx_reg;
        f1_val_reg  <= f0_val_reg;
        pos_reg     <= pos_next;
    end

    // segment base: floor of the position, held inside the table
    always_comb begin
        base_raw = pos_reg[tcli_pkg::POS_W-1] ? 19'd0 : pos_reg[34:16];
        if (base_raw > {3'b0, seg_last_reg}) begin
            base = seg_last_reg;
        end else begin
            base = base_raw[15:0];
        end
    end

    assign load_in_range = 17'(f1_idx_reg) < 17'(TABLE_DEPTH);

    always_comb begin
        q_entry.is_load = (f1_mode_reg == tcli_pkg::MODE_LOAD);
        q_entry.wval    = f1_val_reg;
        q_entry.addr    = q_entry.is_load ? f1_idx_reg : base;
        q_entry.frac    = pos_reg - $signed({3'b0, base, 16'b0});
    end

    // out-of-range loads are dropped here
    assign q_push = f1_valid_reg && (f1_mode_reg == tcli_pkg::MODE_EVAL || load_in_range);

endmodule

// ===== rtl/tcli_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcli_queue
// Small FIFO of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
module tcli_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tcli_pkg::qent_t      push_entry,
    input  logic                 pop,
    output tcli_pkg::qent_t      head,
    output tcli_pkg::qstat_t     stat
);

    tcli_pkg::qent_t                 slot_reg [tcli_pkg::QDEPTH];
    logic [tcli_pkg::QPTR_W-1:0]     wptr_reg;
    logic [tcli_pkg::QPTR_W-1:0]     rptr_reg;
    logic [tcli_pkg::QLVL_W-1:0]     level_reg;
    logic [tcli_pkg::QLVL_W-1:0]     level_next;

    always_comb begin
        level_next = level_reg;
        if (push && !pop) begin
            level_next = level_reg + 3'd1;
        end else if (pop && !push) begin
            level_next = level_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 2'd1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 2'd1;
            end
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_entry;
        end
    end

    assign head           = slot_reg[rptr_reg];
    assign stat.not_empty = (level_reg != '0);
    assign stat.level     = level_reg;

endmodule

// ===== rtl/tcli_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcli_back
// Curve table, neighbor read, slope multiply, rounding divide by 65535
// and saturation, ending in the output register.
// ----------------------------------------------------------------------------
module tcli_back #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tcli_pkg::qent_t      head,
    input  tcli_pkg::qstat_t     q_stat,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,
    output logic                 m_tuser
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [tcli_pkg::ENTRY_W-1:0] curve_mem [TABLE_DEPTH];

    logic                 adv;
    logic [AW-1:0]        rd_addr0;
    logic [AW-1:0]        rd_addr1;

    // stage 1: table read
    logic                                 b1_valid_reg;
    logic [tcli_pkg::ENTRY_W-1:0]         lo_val_reg;
    logic [tcli_pkg::ENTRY_W-1:0]         hi_val_reg;
    logic signed [tcli_pkg::POS_W-1:0]    b1_frac_reg;

    // stage 2: partial products
    logic signed [16:0]                   slope;
    logic signed [17:0]                   frac_lo;
    logic signed [17:0]                   frac_hi;
    logic                                 b2_valid_reg;
    logic [tcli_pkg::ENTRY_W-1:0]         b2_base_reg;
    logic signed [tcli_pkg::PROD_W-1:0]   plo_reg;
    logic signed [tcli_pkg::PROD_W-1:0]   phi_reg;

    // stage 3: numerator plus half
    logic                                 b3_valid_reg;
    logic signed [tcli_pkg::NUM_W-1:0]    num_reg;
    logic signed [tcli_pkg::NUM_W-1:0]    num_next;

    // divide by 65535 and saturate
    logic                                 sat_hi;
    logic                                 sat_lo;
    logic [tcli_pkg::POS_W-1:0]           num_ofs;
    logic [19:0]                          fold1;
    logic [16:0]                          fold2;
    logic [18:0]                          quot;
    logic signed [tcli_pkg::RESULT_W-1:0] res_next;

    logic                                 out_valid_reg;
    logic signed [tcli_pkg::RESULT_W-1:0] result_reg;
    logic                                 clip_reg;

    assign adv   = !out_valid_reg || m_tready;
    assign q_pop = adv && q_stat.not_empty;

    assign rd_addr0 = head.addr[AW-1:0];
    assign rd_addr1 = rd_addr0 + AW'(1);

    // write and read share the stream order, so a load is seen by later reads
    always_ff @(posedge aclk) begin
        if (q_pop && head.is_load) begin
            curve_mem[rd_addr0] <= head.wval;
        end
        if (adv) begin
            lo_val_reg <= curve_mem[rd_addr0];
            hi_val_reg <= curve_mem[rd_addr1];
        end
    end

    assign slope   = $signed({1'b0, hi_val_reg}) - $signed({1'b0, lo_val_reg});
    assign frac_lo = $signed({1'b0, b1_frac_reg[16:0]});
    assign frac_hi = b1_frac_reg[34:17];

    assign num_next = $signed({21'b0, b2_base_reg, 16'b0})
                    + $signed({{18{plo_reg[tcli_pkg::PROD_W-1]}}, plo_reg})
                    + $signed({phi_reg[tcli_pkg::PROD_W-1], phi_reg, 17'b0})
                    + $signed(tcli_pkg::ROUND_HALF);

    // x = H*65536 + L = H*65535 + (H + L); fold twice, then one correction
    always_comb begin
        sat_hi   = num_reg >= tcli_pkg::SAT_HI;
        sat_lo   = num_reg < tcli_pkg::SAT_LO;
        num_ofs  = num_reg[tcli_pkg::POS_W-1:0] + tcli_pkg::SAT_OFS;
        fold1    = 20'(num_ofs[34:16]) + 20'(num_ofs[15:0]);
        fold2    = 17'(fold1[19:16]) + 17'(fold1[15:0]);
        quot     = num_ofs[34:16] + 19'(fold1[19:16]) + 19'(fold2 >= 17'd65535);
        if (sat_hi) begin
            res_next = tcli_pkg::RES_MAX;
        end else if (sat_lo) begin
            res_next = tcli_pkg::RES_MIN;
        end else begin
            res_next = $signed({~quot[18], quot[17:0]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            b1_valid_reg  <= q_pop && !head.is_load;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            out_valid_reg <= b3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b1_frac_reg <= head.frac;
            b2_base_reg <= lo_val_reg;
            plo_reg     <= slope * frac_lo;
            phi_reg     <= slope * frac_hi;
            num_reg     <= num_next;
            result_reg  <= res_next;
            clip_reg    <= sat_hi || sat_lo;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, result_reg};
    assign m_tuser  = clip_reg;

endmodule

// ===== rtl/transfer_curve_lut_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transfer_curve_lut_interpolator
// Transfer curve table with linear interpolation and edge extrapolation.
//
//  channel  dir  handshake              payload
//  s_       in   s_tvalid / s_tready    tdata: index, value, sample; tuser: mode
//  m_       out  m_tvalid / m_tready    tdata: result_value; tuser: clipped
//  cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One item per clock sustained while the output is not stalled. An evaluate
//  reaches m_ through 2 front stages, the queue, then table read, multiply,
//  sum and divide/saturate into the output register.
//  Loads write the table on leaving the queue and give no result.
//  Reset clears control only; the table holds garbage until loaded.
//  An output stall freezes the back end; the front keeps taking transfers
//  until the 4-entry queue is committed, then drops s_tready.
// ----------------------------------------------------------------------------
module transfer_curve_lut_interpolator #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [15:0] entry_index, [31:16] entry_value,
                                   // [49:32] sample_in, [55:50] zero
    input  logic        s_tuser,   // [0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [18:0] result_value, [23:19] zero
    output logic        m_tuser,   // [0] clipped

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);

    `include "assert_macros.svh"

    tcli_pkg::cfg_t   cfg_reg;
    tcli_pkg::qstat_t q_stat;
    tcli_pkg::qent_t  q_entry;
    tcli_pkg::qent_t  q_head;
    logic             q_push;
    logic             q_pop;

    logic signed [tcli_pkg::RESULT_W-1:0] m_result;
    logic                                 on_rail;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.used_entries <= tcli_pkg::USED_ENTRIES_RST;
            cfg_reg.entry_format <= tcli_pkg::ENTRY_FORMAT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tcli_pkg::REG_USED_ENTRIES: cfg_reg.used_entries <= cfg_data;
                tcli_pkg::REG_ENTRY_FORMAT: cfg_reg.entry_format <= cfg_data[0];
                default: ;
            endcase
        end
    end

    tcli_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    tcli_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    tcli_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    assign m_result = m_tdata[tcli_pkg::RESULT_W-1:0];
    assign on_rail  = (m_result == tcli_pkg::RES_MAX) || (m_result == tcli_pkg::RES_MIN);

    // front credit must keep the queue from overrunning
    `TCLI_ASSERT(a_queue_no_overrun, q_push && !q_pop |-> q_stat.level < 3'(tcli_pkg::QDEPTH))
    `TCLI_NEVER(a_no_pop_when_empty, q_pop && !q_stat.not_empty)
    `TCLI_ASSERT(a_clip_on_rail, m_tvalid && m_tuser |-> on_rail)

endmodule

// ===== tb/tcli_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcli_checker
// Watches the input, output and register channels of the transfer curve
// interpolator, keeps its own copy of the curve table and registers, and
// compares every output transfer with the oldest predicted curve value.
// ----------------------------------------------------------------------------
module tcli_checker
    import tcli_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        s_tuser,

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,

    output int          mismatch_count,
    output int          pending_results
);

    typedef struct packed {
        logic signed [RESULT_W-1:0] value;
        logic                       clipped;
    } curve_out_t;

    logic [ENTRY_W-1:0] curve_mem [TABLE_DEPTH];
    logic [USED_W-1:0]  used_reg;
    logic               fmt_reg;
    curve_out_t         expected_vals[$];
    int                 err_total = 0;

    // table position = sample * (points - 1) in Q.16; segment clamped to the
    // table so that both ends extrapolate along the edge segments
    function automatic curve_out_t interp_curve(input logic signed [SAMPLE_W-1:0] smp);
        longint     npts, segs, pos, seg, frac, lo, hi, num, twice, quo;
        curve_out_t res;
        npts = longint'(used_reg);
        if (npts < 2) npts = 2;
        if (npts > TABLE_DEPTH) npts = TABLE_DEPTH;
        segs = npts - 1;
        pos  = longint'(smp) * segs;
        seg  = (pos < 0) ? 0 : (pos >>> 16);
        if (seg > segs - 1) seg = segs - 1;
        frac = pos - seg * 65536;
        lo   = longint'(curve_mem[seg]);
        hi   = longint'(curve_mem[seg + 1]);
        num  = lo * 65536 + (hi - lo) * frac;
        // divide by 65535, round to nearest, floor division for negatives
        twice = 2 * num + 65535;
        if (twice >= 0)
            quo = twice / 131070;
        else
            quo = -((-twice + 131069) / 131070);
        res.clipped = 1'b0;
        if (quo > 262143) begin
            quo = 262143;
            res.clipped = 1'b1;
        end else if (quo < -262144) begin
            quo = -262144;
            res.clipped = 1'b1;
        end
        res.value = quo[RESULT_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        logic [ENTRY_W-1:0] ld_idx;
        logic [ENTRY_W-1:0] ld_val;
        curve_out_t         want;
        curve_out_t         got;
        if (!aresetn) begin
            expected_vals.delete();
            used_reg = USED_ENTRIES_RST;
            fmt_reg  = ENTRY_FORMAT_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_USED_ENTRIES)
                    used_reg = cfg_data;
                else
                    fmt_reg = cfg_data[0];
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == MODE_LOAD) begin
                    ld_idx = s_tdata[15:0];
                    ld_val = s_tdata[31:16];
                    if (ld_idx < TABLE_DEPTH)
                        curve_mem[ld_idx] = (fmt_reg == FMT_BYTE) ?
                                            {ld_val[7:0], ld_val[7:0]} : ld_val;
                end else begin
                    expected_vals.push_back(interp_curve(s_tdata[49:32]));
                end
            end
            if (m_tvalid && m_tready) begin
                got.value   = m_tdata[RESULT_W-1:0];
                got.clipped = m_tuser;
                if (expected_vals.size() == 0) begin
                    err_total++;
                    $display("%0t: unexpected result, value %0d clipped %0b",
                             $time, got.value, got.clipped);
                end else begin
                    want = expected_vals.pop_front();
                    if (got.value !== want.value || got.clipped !== want.clipped) begin
                        err_total++;
                        $display("%0t: mismatch, expected %0d/%0b, got %0d/%0b",
                                 $time, want.value, want.clipped, got.value, got.clipped);
                    end
                end
            end
        end
        mismatch_count  <= err_total;
        pending_results <= expected_vals.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the transfer curve interpolator: fills the curve table, runs a
// directed set of loads and samples at the range edges, then random mixes of
// loads and samples under a series of register settings, with random gaps on
// the input and random stalls on the output. A checker module predicts and
// compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import tcli_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int STALL_LIMIT  = 4000;  // cycles with no transfer anywhere
    localparam int DRAIN_CYCLES = 24;    // pipeline depth plus margin
    localparam int HOLD_CYCLES  = 400;   // long output hold-off
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 130;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;
    logic        s_tuser   = MODE_LOAD;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_USED_ENTRIES;
    logic [16:0] cfg_data  = '0;
    logic        hold_req  = 1'b0;
    int          mismatch_count;
    int          pending_results;

    logic [16:0] phase_used [NUM_PHASES] = '{17'd256, 17'd2, 17'd0, 17'd1, 17'd65536,
                                             17'd131071, 17'd17, 17'd255, 17'd257, 17'd100};
    logic        phase_fmt  [NUM_PHASES] = '{FMT_WORD, FMT_BYTE, FMT_WORD, FMT_BYTE, FMT_WORD,
                                             FMT_BYTE, FMT_WORD, FMT_BYTE, FMT_WORD, FMT_BYTE};

    transfer_curve_lut_interpolator #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    tcli_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_results(pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // mostly short, a few long
    function automatic int draw_gap(input bit nonzero);
        int r;
        r = $urandom_range(0, 99);
        if (!nonzero && r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_sample();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 40) return SAMPLE_W'($urandom);
        if (r < 75) return SAMPLE_W'($urandom_range(0, 65536));
        if (r < 85) begin
            v = $urandom_range(0, 600);
            return SAMPLE_W'(v - 300);
        end
        if (r < 95) return SAMPLE_W'($urandom_range(65236, 65836));
        return (r < 97) ? 18'h20000 : 18'h1FFFF;
    endfunction

    function automatic logic [ENTRY_W-1:0] draw_entry();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return ENTRY_W'($urandom);
    endfunction

    task automatic send_item(input logic kind, input logic [15:0] idx,
                             input logic [15:0] val, input logic [SAMPLE_W-1:0] smp,
                             input bit allow_gap);
        int gap;
        gap = allow_gap ? draw_gap(1'b0) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, smp, val, idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    // returns 1 when the item counts (i.e. is not an ignored load)
    task automatic random_item(input bit allow_gap, output bit counted);
        logic [15:0] idx;
        if ($urandom_range(0, 99) < 30) begin
            if ($urandom_range(0, 9) == 0)
                idx = 16'($urandom_range(TABLE_DEPTH, 65535));
            else
                idx = 16'($urandom_range(0, TABLE_DEPTH - 1));
            send_item(MODE_LOAD, idx, draw_entry(), SAMPLE_W'($urandom), allow_gap);
            counted = (idx < TABLE_DEPTH);
        end else begin
            send_item(MODE_EVAL, 16'($urandom), 16'($urandom), draw_sample(), allow_gap);
            counted = 1'b1;
        end
    endtask

    // loads give no result, so let the pipeline empty after the last one
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [16:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // output side: random runs of ready and stalls, plus one long hold-off
    initial begin : receiver
        int  run_left;
        int  stall_left;
        int  hold_left;
        bit  hold_done;
        run_left   = 0;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_tready <= 1'b1;
            end else begin
                run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 200)
                                                         : $urandom_range(0, 8);
                stall_left = draw_gap(1'b1);
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int  ph;
        int  n_done;
        bit  counted;
        bit  gaps_on;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(REG_USED_ENTRIES, 17'd256);
        write_reg(REG_ENTRY_FORMAT, {16'h0000, FMT_WORD});

        // whole table defined before any sample reads it
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(MODE_LOAD, 16'(i), draw_entry(), SAMPLE_W'($urandom), 1'b1);

        // steep edge segments: both ends extrapolate far enough to clip
        send_item(MODE_LOAD, 16'd0,   16'h0000, '0, 1'b1);
        send_item(MODE_LOAD, 16'd1,   16'hFFFF, '0, 1'b1);
        send_item(MODE_LOAD, 16'd254, 16'h0000, '0, 1'b1);
        send_item(MODE_LOAD, 16'd255, 16'hFFFF, '0, 1'b1);
        send_item(MODE_LOAD, 16'hFFFF, 16'h1234, '0, 1'b1);  // out of range
        send_item(MODE_LOAD, 16'd256, 16'h4321, '0, 1'b1);   // out of range
        send_item(MODE_EVAL, 16'hFFFF, 16'hFFFF, 18'h20000, 1'b1);
        send_item(MODE_EVAL, 16'h0000, 16'h0000, 18'h1FFFF, 1'b1);
        send_item(MODE_EVAL, '0, '0, 18'h00000, 1'b1);
        send_item(MODE_EVAL, '0, '0, 18'h10000, 1'b1);
        send_item(MODE_EVAL, '0, '0, 18'h0FFFF, 1'b1);
        send_item(MODE_EVAL, '0, '0, 18'h3FFFF, 1'b1);
        send_item(MODE_EVAL, '0, '0, 18'h00001, 1'b1);
        send_item(MODE_EVAL, '0, '0, 18'h08000, 1'b1);
        settle();

        // byte entries: high byte dropped, low byte replicated
        write_reg(REG_ENTRY_FORMAT, {16'hFFFF, FMT_BYTE});
        send_item(MODE_LOAD, 16'd2, 16'hA53C, '0, 1'b1);
        send_item(MODE_LOAD, 16'd3, 16'h00FF, '0, 1'b1);
        send_item(MODE_LOAD, 16'd4, 16'hFF00, '0, 1'b1);
        send_item(MODE_EVAL, '0, '0, 18'd600, 1'b1);
        send_item(MODE_EVAL, '0, '0, 18'd800, 1'b1);
        send_item(MODE_EVAL, '0, '0, 18'd1000, 1'b1);
        settle();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == NUM_PHASES - 1)
                write_reg(REG_USED_ENTRIES, 17'($urandom_range(2, 300)));
            else
                write_reg(REG_USED_ENTRIES, phase_used[ph]);
            write_reg(REG_ENTRY_FORMAT, {16'($urandom), phase_fmt[ph]});
            gaps_on = (ph % 4 != 3);
            if (ph == 3) begin
                // sender offers back to back while the output is held
                hold_req <= 1'b1;
                gaps_on = 1'b0;
            end
            n_done = 0;
            while (n_done < PHASE_ITEMS) begin
                random_item(gaps_on, counted);
                if (counted) n_done++;
            end
            settle();
        end

        if (mismatch_count == 0 && pending_results == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
